FILE: hw/rtl/psra_pkg.sv
// ----------------------------------------------------------------------------
// psra_pkg
// Shared types and constants of the page slot range allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package psra_pkg;

  localparam int DATA_W = 34;
  localparam int OFFSET_W = 33;
  localparam int SIZE_W = 32;

  localparam logic [DATA_W-1:0] WINDOW_BASE = 34'h1_0000_0000;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_OUT_OF_WINDOW = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_NEED, S_NEED2,
    S_ARD, S_ACHK, S_ASPL1, S_ASPL2, S_ATOP, S_ATOP2, S_ATOP3,
    S_SHRD, S_SHWR,
    S_RCLAMP, S_RCLAMP2, S_RRD, S_RCHK, S_RP1, S_RP2,
    S_RM1, S_RM2, S_RM3, S_RM4, S_RM5, S_RM6, S_RM7,
    S_RS1, S_RS2, S_RS3, S_RS4, S_RS5,
    S_RINS, S_UPRD, S_UPWR, S_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/psra_ram.sv
// ----------------------------------------------------------------------------
// psra_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/psra_alu.sv
// ----------------------------------------------------------------------------
// psra_alu
// Shared adder/subtractor with less-than and equal flags.
// ----------------------------------------------------------------------------
`default_nettype none

module psra_alu (
  input  wire psra_pkg::alu_op_t              op,
  input  wire logic [psra_pkg::DATA_W-1:0]    a,
  input  wire logic [psra_pkg::DATA_W-1:0]    b,
  output logic      [psra_pkg::DATA_W-1:0]    res,
  output logic                                lt,
  output logic                                eq
);

  import psra_pkg::*;

  always_comb begin
    case (op)
      ALU_ADD: res = a + b;
      ALU_SUB: res = a - b;
      default: res = a + b;
    endcase
  end

  assign lt = (a < b);
  assign eq = (a == b);

endmodule

`default_nettype wire

FILE: hw/rtl/page_slot_range_allocator_core.sv
// ----------------------------------------------------------------------------
// page_slot_range_allocator_core
// First-fit page slot allocator over a start-sorted table of free ranges,
// with coalescing on release and a top pointer fallback.
// ----------------------------------------------------------------------------
//   channel | handshake          | word
//   req     | req_valid/stall    | mode, size_bytes, release_offset
//   rsp     | rsp_valid/stall    | granted_offset, status
//
// One request at a time; each table entry walked takes a read and a check
// state and each entry moved a read and a write state on the registered-read
// table RAM (one write, one read port), plus steps on the shared adder.
// Reset empties the table (count to zero) and clears the top pointer.
// The next request is taken while a result waits on a stalled rsp.
`default_nettype none

module page_slot_range_allocator_core #(
  parameter int SLOT_INDEX_BITS = 20,
  parameter int RANGE_ENTRIES = 256,
  parameter int PAGE_SHIFT = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic                              mode,
  input  wire logic [psra_pkg::SIZE_W-1:0]       size_bytes,
  input  wire logic [psra_pkg::OFFSET_W-1:0]     release_offset,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic      [psra_pkg::OFFSET_W-1:0]     granted_offset,
  output psra_pkg::status_t                      status
);

  import psra_pkg::*;

  localparam int SB = SLOT_INDEX_BITS;
  localparam int CB = SLOT_INDEX_BITS + 1;
  localparam int AW = $clog2(RANGE_ENTRIES);
  localparam int IW = $clog2(RANGE_ENTRIES + 1);
  localparam int ShW = SLOT_INDEX_BITS + PAGE_SHIFT + OFFSET_W;
  localparam logic [DATA_W-1:0] MaxSlots = DATA_W'(1) << SLOT_INDEX_BITS;
  localparam logic [DATA_W-1:0] PageMask = (DATA_W'(1) << PAGE_SHIFT) - DATA_W'(1);

  state_t state, state_next;
  logic            mode_r, mode_r_next;
  logic [SIZE_W-1:0] size_r, size_r_next;
  logic            win_bad, win_bad_next;
  logic [SB-1:0]   start, start_next;
  logic [DATA_W-1:0] need, need_next, cnt, cnt_next, acc, acc_next;
  logic [DATA_W-1:0] room, room_next, tmp, tmp_next;
  logic [SB-1:0]   prev_first, prev_first_next, cur_first, cur_first_next;
  logic [CB-1:0]   prev_cnt, prev_cnt_next, cur_cnt, cur_cnt_next;
  logic            prev_ok, prev_ok_next, cur_ok, cur_ok_next;
  logic [IW-1:0]   j, j_next, k, k_next, n, n_next;
  logic [CB-1:0]   top, top_next;
  logic            res_grant, res_grant_next;
  status_t         res_stat, res_stat_next;
  logic            rsp_valid_next;
  logic [OFFSET_W-1:0] granted_next;
  status_t         status_next;

  alu_op_t           alu_op;
  logic [DATA_W-1:0] alu_a, alu_b, alu_res;
  logic              alu_lt, alu_eq;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [SB+CB-1:0]  wdata, rdata;
  logic [SB-1:0]     rd_first;
  logic [CB-1:0]     rd_cnt;

  logic [OFFSET_W-1:0] slot_w;
  logic [IW-1:0]       jm1, kp1, km1;
  logic [ShW-1:0]      shx;
  logic [DATA_W-1:0]   need_sh;

  psra_ram #(.WIDTH(SB + CB), .DEPTH(RANGE_ENTRIES)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  psra_alu u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res), .lt(alu_lt), .eq(alu_eq)
  );

  assign rd_first = rdata[SB+CB-1:CB];
  assign rd_cnt = rdata[CB-1:0];
  assign slot_w = OFFSET_W'({1'b0, release_offset[SIZE_W-1:0]} >> PAGE_SHIFT);
  assign jm1 = j - IW'(1);
  assign kp1 = k + IW'(1);
  assign km1 = k - IW'(1);
  assign shx = ShW'(start) << PAGE_SHIFT;
  assign need_sh = acc >> PAGE_SHIFT;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    mode_r_next = mode_r;
    size_r_next = size_r;
    win_bad_next = win_bad;
    start_next = start;
    need_next = need;
    cnt_next = cnt;
    acc_next = acc;
    room_next = room;
    tmp_next = tmp;
    prev_first_next = prev_first;
    prev_cnt_next = prev_cnt;
    prev_ok_next = prev_ok;
    cur_first_next = cur_first;
    cur_cnt_next = cur_cnt;
    cur_ok_next = cur_ok;
    j_next = j;
    k_next = k;
    n_next = n;
    top_next = top;
    res_grant_next = res_grant;
    res_stat_next = res_stat;
    rsp_valid_next = rsp_valid;
    granted_next = granted_offset;
    status_next = status;
    alu_op = ALU_ADD;
    alu_a = '0;
    alu_b = '0;
    we = 1'b0;
    waddr = j[AW-1:0];
    wdata = '0;
    raddr = j[AW-1:0];

    if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          mode_r_next = mode;
          size_r_next = size_bytes;
          win_bad_next = !release_offset[SIZE_W] || (|(slot_w >> SLOT_INDEX_BITS));
          start_next = slot_w[SB-1:0];
          state_next = S_NEED;
        end
      end
      S_NEED: begin
        alu_a = DATA_W'(size_r);
        alu_b = PageMask;
        acc_next = alu_res;
        state_next = S_NEED2;
      end
      S_NEED2: begin
        need_next = (need_sh == '0) ? DATA_W'(1) : need_sh;
        j_next = '0;
        prev_ok_next = 1'b0;
        cur_ok_next = 1'b0;
        res_grant_next = 1'b0;
        res_stat_next = ST_DONE;
        if (mode_r == MODE_ALLOC) begin
          state_next = S_ARD;
        end else if (win_bad) begin
          res_stat_next = ST_OUT_OF_WINDOW;
          state_next = S_FIN;
        end else begin
          state_next = S_RCLAMP;
        end
      end
      S_ARD: begin
        if (j == n) begin
          state_next = S_ATOP;
        end else begin
          state_next = S_ACHK;
        end
      end
      S_ACHK: begin
        alu_a = DATA_W'(rd_cnt);
        alu_b = need;
        cur_first_next = rd_first;
        cur_cnt_next = rd_cnt;
        if (!alu_lt) begin
          start_next = rd_first;
          res_grant_next = 1'b1;
          if (alu_eq) begin
            k_next = j;
            state_next = S_SHRD;
          end else begin
            state_next = S_ASPL1;
          end
        end else begin
          j_next = j + IW'(1);
          state_next = S_ARD;
        end
      end
      S_ASPL1: begin
        alu_a = DATA_W'(cur_first);
        alu_b = need;
        acc_next = alu_res;
        state_next = S_ASPL2;
      end
      S_ASPL2: begin
        alu_op = ALU_SUB;
        alu_a = DATA_W'(cur_cnt);
        alu_b = need;
        we = 1'b1;
        wdata = {acc[SB-1:0], alu_res[CB-1:0]};
        state_next = S_FIN;
      end
      S_ATOP: begin
        alu_op = ALU_SUB;
        alu_a = MaxSlots;
        alu_b = DATA_W'(top);
        room_next = alu_res;
        state_next = S_ATOP2;
      end
      S_ATOP2: begin
        alu_a = room;
        alu_b = need;
        if (alu_lt) begin
          res_stat_next = ST_NO_SPACE;
          state_next = S_FIN;
        end else begin
          start_next = top[SB-1:0];
          res_grant_next = 1'b1;
          state_next = S_ATOP3;
        end
      end
      S_ATOP3: begin
        alu_a = DATA_W'(top);
        alu_b = need;
        top_next = alu_res[CB-1:0];
        state_next = S_FIN;
      end
      S_SHRD: begin
        raddr = kp1[AW-1:0];
        if (kp1 >= n) begin
          n_next = n - IW'(1);
          state_next = S_FIN;
        end else begin
          state_next = S_SHWR;
        end
      end
      S_SHWR: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wdata = rdata;
        k_next = kp1;
        state_next = S_SHRD;
      end
      S_RCLAMP: begin
        alu_op = ALU_SUB;
        alu_a = MaxSlots;
        alu_b = DATA_W'(start);
        room_next = alu_res;
        state_next = S_RCLAMP2;
      end
      S_RCLAMP2: begin
        alu_a = room;
        alu_b = need;
        cnt_next = alu_lt ? room : need;
        state_next = S_RRD;
      end
      S_RRD: begin
        if (j == n) begin
          state_next = S_RP1;
        end else begin
          state_next = S_RCHK;
        end
      end
      S_RCHK: begin
        alu_a = DATA_W'(rd_first);
        alu_b = DATA_W'(start);
        if (alu_lt) begin
          prev_first_next = rd_first;
          prev_cnt_next = rd_cnt;
          prev_ok_next = 1'b1;
          j_next = j + IW'(1);
          state_next = S_RRD;
        end else begin
          cur_first_next = rd_first;
          cur_cnt_next = rd_cnt;
          cur_ok_next = 1'b1;
          state_next = S_RP1;
        end
      end
      S_RP1: begin
        alu_a = DATA_W'(prev_first);
        alu_b = DATA_W'(prev_cnt);
        tmp_next = alu_res;
        state_next = prev_ok ? S_RP2 : S_RS1;
      end
      S_RP2: begin
        alu_a = tmp;
        alu_b = DATA_W'(start);
        state_next = alu_eq ? S_RM1 : S_RS1;
      end
      S_RM1: begin
        alu_a = DATA_W'(prev_cnt);
        alu_b = cnt;
        acc_next = alu_res;
        state_next = S_RM2;
      end
      S_RM2: begin
        alu_op = ALU_SUB;
        alu_a = MaxSlots;
        alu_b = DATA_W'(prev_first);
        room_next = alu_res;
        state_next = S_RM3;
      end
      S_RM3: begin
        alu_a = room;
        alu_b = acc;
        if (alu_lt) begin
          acc_next = room;
        end
        state_next = S_RM4;
      end
      S_RM4: begin
        alu_a = DATA_W'(prev_first);
        alu_b = acc;
        tmp_next = alu_res;
        state_next = S_RM5;
      end
      S_RM5: begin
        alu_a = tmp;
        alu_b = DATA_W'(cur_first);
        if (cur_ok && alu_eq) begin
          state_next = S_RM6;
        end else begin
          we = 1'b1;
          waddr = jm1[AW-1:0];
          wdata = {prev_first, acc[CB-1:0]};
          state_next = S_FIN;
        end
      end
      S_RM6: begin
        alu_a = acc;
        alu_b = DATA_W'(cur_cnt);
        acc_next = alu_res;
        state_next = S_RM7;
      end
      S_RM7: begin
        alu_a = room;
        alu_b = acc;
        we = 1'b1;
        waddr = jm1[AW-1:0];
        wdata = {prev_first, alu_lt ? room[CB-1:0] : acc[CB-1:0]};
        k_next = j;
        state_next = S_SHRD;
      end
      S_RS1: begin
        alu_a = DATA_W'(start);
        alu_b = cnt;
        tmp_next = alu_res;
        state_next = cur_ok ? S_RS2 : S_RINS;
      end
      S_RS2: begin
        alu_a = tmp;
        alu_b = DATA_W'(cur_first);
        state_next = alu_eq ? S_RS3 : S_RINS;
      end
      S_RS3: begin
        alu_a = cnt;
        alu_b = DATA_W'(cur_cnt);
        acc_next = alu_res;
        state_next = S_RS4;
      end
      S_RS4: begin
        alu_op = ALU_SUB;
        alu_a = MaxSlots;
        alu_b = DATA_W'(start);
        room_next = alu_res;
        state_next = S_RS5;
      end
      S_RS5: begin
        alu_a = room;
        alu_b = acc;
        we = 1'b1;
        wdata = {start, alu_lt ? room[CB-1:0] : acc[CB-1:0]};
        state_next = S_FIN;
      end
      S_RINS: begin
        if (n == IW'(RANGE_ENTRIES)) begin
          res_stat_next = ST_TABLE_FULL;
          state_next = S_FIN;
        end else begin
          k_next = n;
          state_next = S_UPRD;
        end
      end
      S_UPRD: begin
        raddr = km1[AW-1:0];
        if (k == j) begin
          we = 1'b1;
          wdata = {start, cnt[CB-1:0]};
          n_next = n + IW'(1);
          state_next = S_FIN;
        end else begin
          state_next = S_UPWR;
        end
      end
      S_UPWR: begin
        we = 1'b1;
        waddr = k[AW-1:0];
        wdata = rdata;
        k_next = km1;
        state_next = S_UPRD;
      end
      S_FIN: begin
        alu_a = WINDOW_BASE;
        alu_b = DATA_W'(shx[OFFSET_W-1:0]);
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next = 1'b1;
          granted_next = res_grant ? alu_res[OFFSET_W-1:0] : '0;
          status_next = res_stat;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      top <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      n <= n_next;
      top <= top_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_r_next;
    size_r <= size_r_next;
    win_bad <= win_bad_next;
    start <= start_next;
    need <= need_next;
    cnt <= cnt_next;
    acc <= acc_next;
    room <= room_next;
    tmp <= tmp_next;
    prev_first <= prev_first_next;
    prev_cnt <= prev_cnt_next;
    prev_ok <= prev_ok_next;
    cur_first <= cur_first_next;
    cur_cnt <= cur_cnt_next;
    cur_ok <= cur_ok_next;
    j <= j_next;
    k <= k_next;
    res_grant <= res_grant_next;
    res_stat <= res_stat_next;
    granted_offset <= granted_next;
    status <= status_next;
  end

`ifndef SYNTHESIS
  a_table_bound: assert property (@(posedge clk) disable iff (rst)
    n <= IW'(RANGE_ENTRIES))
    else $error("range table count past capacity");

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    DATA_W'(top) <= MaxSlots)
    else $error("top pointer past window end");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_DONE |-> granted_offset == '0)
    else $error("nonzero offset on failed request");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_FIN)
    else $error("response raised outside finish step");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    n != $past(n) |-> (n == $past(n) + IW'(1)) || (n == $past(n) - IW'(1)))
    else $error("range count moved by more than one");
`endif

endmodule

`default_nettype wire

FILE: bench/page_slot_range_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// page_slot_range_allocator_core_tb
// Drives allocate and release requests into the slot allocator, predicts
// each response word with a behavioral first-fit free range table, and
// compares granted offset and status in order under random idling and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module page_slot_range_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psra_pkg::*;

  localparam int SLOT_BITS = 20;
  localparam int ENTRIES = 256;
  localparam int PSHIFT = 12;
  localparam longint SLOT_LIMIT = 64'd1 << SLOT_BITS;
  localparam longint BASE_OFF = 64'h1_0000_0000;
  localparam longint OFF_MASK = 64'h1_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 2000;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    status_t st;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic mode = MODE_ALLOC;
  logic [SIZE_W-1:0] size_bytes = '0;
  logic [OFFSET_W-1:0] release_offset = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [OFFSET_W-1:0] granted_offset;
  status_t status;

  longint free_first[ENTRIES+1];
  longint free_count[ENTRIES+1];
  int free_used;
  longint top_ptr;
  grant_t expected_grants[$];
  int mismatches;
  int cycles;
  bit hold_rsp;
  bit hold_seen = 1'b0;
  int hold_left = 0;
  int gap_max;
  bit stall_on;

  page_slot_range_allocator_core i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .mode(mode), .size_bytes(size_bytes), .release_offset(release_offset),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .granted_offset(granted_offset), .status(status)
  );

  always #5 clk = ~clk;

  function automatic longint clip_count(longint first, longint cnt);
    longint room;
    room = SLOT_LIMIT - first;
    return (cnt > room) ? room : cnt;
  endfunction

  function automatic void drop_range(int i);
    for (int k = i; k + 1 < free_used; k++) begin
      free_first[k] = free_first[k+1];
      free_count[k] = free_count[k+1];
    end
    free_used--;
  endfunction

  function automatic grant_t predict_grant(logic m, logic [SIZE_W-1:0] sz,
                                           logic [OFFSET_W-1:0] off);
    grant_t g;
    longint need, start, cnt, rel;
    int i, k, n;
    g.offset = '0;
    g.st = ST_DONE;
    need = (longint'(sz) + 4095) >> PSHIFT;
    if (need == 0) need = 1;
    if (m == MODE_ALLOC) begin
      for (i = 0; i < free_used; i++) begin
        if (free_count[i] >= need) begin
          start = free_first[i];
          if (free_count[i] == need) drop_range(i);
          else begin
            free_first[i] += need;
            free_count[i] -= need;
          end
          g.offset = (BASE_OFF + (start << PSHIFT)) & OFF_MASK;
          return g;
        end
      end
      if (need > SLOT_LIMIT - top_ptr) begin
        g.st = ST_NO_SPACE;
        return g;
      end
      g.offset = (BASE_OFF + (top_ptr << PSHIFT)) & OFF_MASK;
      top_ptr += need;
      return g;
    end
    if (longint'(off) < BASE_OFF) begin
      g.st = ST_OUT_OF_WINDOW;
      return g;
    end
    rel = longint'(off) - BASE_OFF;
    if ((rel >> PSHIFT) >= SLOT_LIMIT) begin
      g.st = ST_OUT_OF_WINDOW;
      return g;
    end
    start = rel >> PSHIFT;
    cnt = clip_count(start, need);
    n = free_used;
    i = 0;
    while (i < n && free_first[i] < start) i++;
    if (i > 0 && free_first[i-1] + free_count[i-1] == start) begin
      k = i - 1;
      free_count[k] = clip_count(free_first[k], free_count[k] + cnt);
      if (i < n && free_first[k] + free_count[k] == free_first[i]) begin
        free_count[k] = clip_count(free_first[k], free_count[k] + free_count[i]);
        drop_range(i);
      end
    end else if (i < n && start + cnt == free_first[i]) begin
      free_count[i] = clip_count(start, cnt + free_count[i]);
      free_first[i] = start;
    end else begin
      if (n >= ENTRIES) begin
        g.st = ST_TABLE_FULL;
        return g;
      end
      for (k = n; k > i; k--) begin
        free_first[k] = free_first[k-1];
        free_count[k] = free_count[k-1];
      end
      free_first[i] = start;
      free_count[i] = cnt;
      free_used = n + 1;
    end
    return g;
  endfunction

  task automatic send_word(logic m, logic [SIZE_W-1:0] sz, logic [OFFSET_W-1:0] off);
    mode <= m;
    size_bytes <= sz;
    release_offset <= off;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_grants.push_back(predict_grant(m, sz, off));
  endtask

  task automatic idle_req(int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
  endtask

  function automatic logic [OFFSET_W-1:0] slot_off(longint slot, int low);
    return (BASE_OFF + (slot << PSHIFT) + low) & OFF_MASK;
  endfunction

  // random size, mostly few slots
  function automatic logic [SIZE_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 8 * 4096);
    if (r < 90) return $urandom_range(0, 64 * 4096);
    if (r < 97) return $urandom_range(0, 32'h0100_0000);
    return $urandom();
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return slot_off($urandom_range(0, 2047), $urandom_range(0, 99) < 10 ?
                                $urandom_range(1, 4095) : 0);
    if (r < 90) return slot_off($urandom_range(0, SLOT_LIMIT - 1), $urandom_range(0, 4095));
    return {1'($urandom_range(0, 1)), $urandom()};
  endfunction

  task automatic test_directed();
    send_word(MODE_ALLOC, 32'd0, '0);
    send_word(MODE_ALLOC, 32'd1, '1);
    send_word(MODE_ALLOC, 32'd4096, '0);
    send_word(MODE_ALLOC, 32'd4097, '0);
    send_word(MODE_RELEASE, 32'd4096, slot_off(1, 0));
    send_word(MODE_RELEASE, 32'd0, slot_off(0, 4095));
    send_word(MODE_RELEASE, 32'd8192, slot_off(2, 0));
    send_word(MODE_RELEASE, 32'd4096, slot_off(1, 0));
    send_word(MODE_RELEASE, 32'd0, 33'h0_FFFF_FFFF);
    send_word(MODE_RELEASE, 32'd0, '0);
    send_word(MODE_RELEASE, 32'd0, 33'h1_FFFF_FFFF);
    send_word(MODE_RELEASE, 32'hFFFF_FFFF, slot_off(SLOT_LIMIT - 2, 0));
    send_word(MODE_ALLOC, 32'hFFFF_FFFF, '0);
    send_word(MODE_ALLOC, 32'd12288, '0);
    send_word(MODE_ALLOC, 32'h0FFF_F000, '0);
    send_word(MODE_ALLOC, 32'd1, '0);
    send_word(MODE_RELEASE, 32'hFFFF_FFFF, slot_off(10, 0));
    send_word(MODE_ALLOC, 32'hFFFF_FFFF, '0);
    drain();
  endtask

  // fill the table with isolated ranges until it overflows
  task automatic test_table_full();
    for (int s = 0; s < ENTRIES + 4; s++)
      send_word(MODE_RELEASE, 32'd0, slot_off(20000 + 2 * s, 0));
    send_word(MODE_RELEASE, 32'd4096, slot_off(20001, 0));
    for (int s = 0; s < 8; s++) send_word(MODE_ALLOC, 32'd8192, '0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_rsp = 1'b1;
    for (int j = 0; j < 40; j++) send_word(MODE_ALLOC, pick_size(), '0);
    hold_rsp = 1'b0;
    drain();
  endtask

  task automatic test_random(int total);
    int burst;
    for (int j = 0; j < total; j++) begin
      if ($urandom_range(0, 99) < 55) send_word(MODE_ALLOC, pick_size(), '0);
      else send_word(MODE_RELEASE, pick_size(), pick_offset());
      if (gap_max > 0 && $urandom_range(0, 7) == 0) idle_req($urandom_range(1, gap_max));
      if ($urandom_range(0, 199) == 0) begin
        burst = $urandom_range(0, 2);
        gap_max = (burst == 0) ? 0 : burst * 6;
        stall_on = $urandom_range(0, 1);
      end
      if (j == total / 2) drain();
    end
    drain();
  endtask

  // long hold-off starts when hold_rsp rises and holds rsp_stall until hold_left runs out
  always @(posedge clk) begin
    hold_seen <= hold_rsp;
    if (hold_rsp && !hold_seen) begin
      hold_left <= HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (!stall_on) rsp_stall <= 1'b0;
    else rsp_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    grant_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: offset %h status %0d",
                                       granted_offset, status);
      end else begin
        e = expected_grants.pop_front();
        if (e.offset !== granted_offset || e.st !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected offset %h status %0d, got offset %h status %0d",
                     e.offset, e.st, granted_offset, status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("page_slot_range_allocator_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    free_used = 0;
    top_ptr = 0;
    mismatches = 0;
    cycles = 0;
    hold_rsp = 1'b0;
    gap_max = 4;
    stall_on = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_backpressure();
    test_random(1200);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_grants.size() == 0)
      $display("page_slot_range_allocator_core_tb: done, clean");
    else
      $display("page_slot_range_allocator_core_tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
